@@ hdl/b128d_pkg.sv @@
`default_nettype none

package b128d_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned LenW   = 2;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CountW = 2;
  localparam int unsigned OutW   = 32;

  localparam logic [CodeW-1:0] CpMax    = 21'h10FFFF;
  localparam logic [CodeW-1:0] TwoMin   = 21'h000080;
  localparam logic [CodeW-1:0] ThreeMin = 21'h004000;

  // continuation bytes taken before the ending byte
  localparam logic [CountW-1:0] PosFirst  = 2'd0;
  localparam logic [CountW-1:0] PosSecond = 2'd1;
  localparam logic [CountW-1:0] PosThird  = 2'd2;
  localparam logic [CountW-1:0] PosBad    = 2'd3;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_OVERLONG  = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [LenW-1:0]   char_length;
    logic [CodeW-1:0]  code_point;
  } result_t;

  typedef struct packed {
    logic [CodeW-1:0]  acc;
    logic [CountW-1:0] count;
  } dec_state_t;

endpackage

`default_nettype wire

@@ hdl/b128d_decode.sv @@
`default_nettype none

module b128d_decode
  import b128d_pkg::*;
(
  input  wire logic [DataW-1:0] data_byte_i,
  input  wire logic             buffer_end_i,
  input  wire dec_state_t       state_i,
  output dec_state_t            state_o,
  output logic                  emit_o,
  output result_t               result_o
);

  logic [CountW-1:0] pos;
  logic [CodeW-1:0]  acc;

  assign pos = (state_i.count == PosBad) ? PosThird : state_i.count;
  assign acc = {state_i.acc[CodeW-8:0], data_byte_i[DataW-2:0]};

  always_comb begin
    emit_o               = 1'b1;
    result_o.status      = ST_OK;
    result_o.char_length = '0;
    result_o.code_point  = '0;
    state_o.acc          = '0;
    state_o.count        = '0;
    if (!data_byte_i[DataW-1]) begin
      // final byte: check form and range
      if (pos == PosSecond && acc < TwoMin) begin
        result_o.status = ST_OVERLONG;
      end else if (pos == PosThird && acc < ThreeMin) begin
        result_o.status = ST_OVERLONG;
      end else if (acc > CpMax) begin
        result_o.status = ST_INVALID;
      end else begin
        result_o.code_point  = acc;
        result_o.char_length = pos + 2'd1;
      end
    end else if (buffer_end_i) begin
      result_o.status = ST_TRUNCATED;
    end else if (pos == PosThird) begin
      result_o.status = ST_TOO_LONG;
    end else begin
      // absorb continuation byte
      emit_o        = 1'b0;
      state_o.acc   = acc;
      state_o.count = pos + 2'd1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/b128d_out_stage.sv @@
`default_nettype none

module b128d_out_stage
  import b128d_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      result_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o   = !vld_q || ready_i;
  assign vld_d    = push_i || (vld_q && !ready_i);
  assign valid_o  = vld_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // load on push; the caller must push only into a free slot
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= result_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/base128_char_decoder_unit.sv @@
// Channel  | Dir | Word                        | Fields (low bit up)
// ---------+-----+-----------------------------+------------------------------------
// s_axis   | in  | one encoded byte            | tdata: data_byte[7:0]; tlast: buffer_end
// m_axis   | out | one decoded char or error   | tdata: code_point[20:0],
//          |     |                             |   char_length[22:21], status[25:23], 0
//
// Takes one byte per cycle unless stalled. A result passes through the input
// register and then the result register. The decode step between them is
// combinational and feeds the running accumulator and byte count back into
// itself.
// Reset clears the valid flags, the accumulator and the byte count.
// A stall on m_axis holds the result register; the input register keeps
// absorbing continuation bytes, and stalls only when it holds a byte that
// produces a result while the result register stays full.
`default_nettype none

module base128_char_decoder_unit
  import b128d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [DataW-1:0] s_axis_tdata_i,   // data_byte[7:0]
  input  wire logic             s_axis_tlast_i,   // buffer_end
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [OutW-1:0]       m_axis_tdata_o    // code_point, char_length, status, zeros
);

  // input register
  logic             in_vld_q, in_vld_d;
  logic [DataW-1:0] in_byte_q;
  logic             in_last_q;
  logic             in_take;

  // running character state
  dec_state_t state_q, state_d;

  logic    emit;
  result_t result;
  result_t out_result;
  logic    out_free;
  logic    advance;
  logic    push;

  b128d_decode u_decode (
    .data_byte_i  (in_byte_q),
    .buffer_end_i (in_last_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .emit_o       (emit),
    .result_o     (result)
  );

  // advance the held byte when it either emits into a free slot or is absorbed
  assign advance = in_vld_q && (!emit || out_free);
  assign push    = advance && emit;

  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_vld_d        = in_take || (in_vld_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  b128d_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .result_i (result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_result)
  );

  // pad the packed result up to whole bytes
  assign m_axis_tdata_o = {(OutW - $bits(result_t))'(0), out_result};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count != PosBad)
    else $error("byte count reached an impossible value");

  a_ok_has_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_result.status == ST_OK) |-> out_result.char_length != '0)
    else $error("ok result without a length");

  a_err_zeroed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_result.status != ST_OK) |->
      (out_result.char_length == '0 && out_result.code_point == '0))
    else $error("error result carries payload");

  a_hold_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> $stable(state_q))
    else $error("character state moved while the byte was held");

endmodule

`default_nettype wire

@@ bench/base128_char_decoder_unit_tb.sv @@
`default_nettype none

module base128_char_decoder_unit_tb;
  import b128d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Bytes to send in the random phase with idling, then in the closing
  // back-to-back phase with both sides always ready.
  localparam int unsigned RandomBytes = 1450;
  localparam int unsigned SteadyBytes = 200;
  localparam int unsigned DrainLimit  = 1000;
  localparam int unsigned MaxReports  = 40;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i;   // data_byte[7:0]
  logic             s_axis_tlast_i;   // buffer_end
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [OutW-1:0]  m_axis_tdata_o;   // code_point[20:0], char_length[22:21],
                                      // status[25:23], zeros

  // Mirror of the decoder's running state, advanced on every accepted byte.
  logic [CodeW-1:0]  mirror_acc;
  logic [CountW-1:0] mirror_count;

  // Decoded characters and errors still owed by the block, oldest first.
  result_t pending_chars[$];

  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned chars_seen;
  int unsigned status_seen [5];
  bit          steady;   // no idling on either side once set

  base128_char_decoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Advance the mirrored state by one byte. Return 1 and fill the result
  // when the byte ends a character or raises an error.
  function automatic bit decode_byte(input logic [DataW-1:0] b, input logic last,
                                     output result_t res);
    logic [CountW-1:0] pos;
    logic [CodeW-1:0]  grown;
    pos = mirror_count;
    // a count of three cannot occur; treat it like the third byte anyway
    if (pos == PosBad) begin
      pos = PosThird;
    end
    // shift in seven payload bits; the top bits fall off at 21
    grown = {mirror_acc[CodeW-8:0], b[6:0]};
    res = '0;
    if (!b[7]) begin
      // ending byte: overlong and range checks come before success
      if ((pos == PosSecond && grown < TwoMin) || (pos == PosThird && grown < ThreeMin)) begin
        res.status = ST_OVERLONG;
      end else if (grown > CpMax) begin
        res.status = ST_INVALID;
      end else begin
        res.status      = ST_OK;
        res.code_point  = grown;
        res.char_length = LenW'(pos) + LenW'(1);
      end
    end else if (last) begin
      // more bytes announced but the buffer ends here
      res.status = ST_TRUNCATED;
    end else if (pos == PosThird) begin
      res.status = ST_TOO_LONG;
    end else begin
      mirror_acc   = grown;
      mirror_count = pos + CountW'(1);
      return 1'b0;
    end
    mirror_acc   = '0;
    mirror_count = PosFirst;
    return 1'b1;
  endfunction

  // Present one byte, wait for its handshake, then queue what it causes.
  // An idle burst lowers tvalid on an earlier falling edge than the one that
  // raises it again, so the two never share a time step.
  task automatic send_byte(input logic [DataW-1:0] b, input logic last);
    int unsigned gap;
    result_t     res;
    gap = (!steady && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    bytes_sent++;
    if (decode_byte(b, last, res)) begin
      pending_chars.push_back(res);
    end
  endtask

  // Encode a value as a big-endian base-128 sequence of len bytes; only the
  // final byte may carry the buffer-end flag.
  task automatic send_char(input logic [CodeW-1:0] value, input int unsigned len,
                           input logic last);
    logic [DataW-1:0] b;
    for (int i = int'(len) - 1; i >= 0; i--) begin
      b = {(i > 0) ? 1'b1 : 1'b0, 7'(value >> (7 * i))};
      send_byte(b, last && (i == 0));
    end
  endtask

  // Receiver: stall in random bursts until the steady phase begins.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 20) - 1) @(negedge clk_i);
    end
  end

  // Compare every accepted output word with the oldest pending expectation.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);
      chars_seen++;
      if (pending_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("%0t: unexpected word: expected none, actual %h", $time,
                   m_axis_tdata_o);
        end
      end else begin
        want = pending_chars.pop_front();
        if (got.status <= ST_TRUNCATED) begin
          status_seen[got.status]++;
        end
        if (got.code_point !== want.code_point || got.char_length !== want.char_length ||
            got.status !== want.status || m_axis_tdata_o[OutW-1:$bits(result_t)] !== '0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display({"%0t: mismatch: expected cp=%h len=%0d st=%0d, ",
                      "actual cp=%h len=%0d st=%0d pad=%h"},
                     $time, want.code_point, want.char_length, want.status, got.code_point,
                     got.char_length, got.status, m_axis_tdata_o[OutW-1:$bits(result_t)]);
          end
        end
      end
    end
  end

  // Single-byte characters at both ends of the range, with and without the
  // buffer-end flag.
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // Two-byte forms: the smallest legal value, the largest, and overlongs.
  task automatic test_two_byte_forms();
    send_char(21'h000080, 2, 1'b0);
    send_char(21'h003FFF, 2, 1'b1);
    send_char(21'h00007F, 2, 1'b0);
    send_char(21'h000000, 2, 1'b0);
  endtask

  // Three-byte forms: range edges, overlong, above range, all ones.
  task automatic test_three_byte_forms();
    send_char(21'h004000, 3, 1'b0);
    send_char(21'h10FFFF, 3, 1'b0);
    send_char(21'h003FFF, 3, 1'b0);
    send_char(21'h110000, 3, 1'b0);
    send_char(21'h1FFFFF, 3, 1'b1);
  endtask

  // Error paths: a third continuation byte, a continuation byte at buffer
  // end, and a clean restart afterwards.
  task automatic test_error_paths();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);   // too long
    send_byte(8'h41, 1'b0);   // fresh character
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);   // third continuation at buffer end
    send_byte(8'h80, 1'b1);   // first byte already truncated
    send_byte(8'h81, 1'b0);
    send_byte(8'hC0, 1'b1);   // second byte truncated
    send_byte(8'h7F, 1'b0);
  endtask

  // Mostly well-formed characters with random content, plus truncated and
  // over-long sequences and plain noise.
  task automatic send_random_run();
    int unsigned kind;
    int unsigned len;
    int unsigned n;
    logic [CodeW-1:0] value;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      len = $urandom_range(1, 3);
      n   = $urandom_range(0, 5);
      case (len)
        1: value = CodeW'($urandom_range(0, 21'h7F));
        2: value = CodeW'((n == 0) ? $urandom_range(0, 21'h7F)
                                   : $urandom_range(21'h80, 21'h3FFF));
        default: begin
          if (n == 0) begin
            value = CodeW'($urandom_range(0, 21'h3FFF));
          end else if (n == 1) begin
            value = CodeW'($urandom_range(21'h110000, 21'h1FFFFF));
          end else begin
            value = CodeW'($urandom_range(21'h4000, 21'h10FFFF));
          end
        end
      endcase
      send_char(value, len, $urandom_range(0, 7) == 0);
    end else if (kind < 80) begin
      // continuation bytes cut off by the end of the buffer
      n = $urandom_range(1, 3);
      for (int i = 0; i < int'(n); i++) begin
        send_byte(8'h80 | 8'($urandom_range(0, 127)), i == int'(n) - 1);
      end
    end else if (kind < 88) begin
      // too many continuation bytes, then maybe an ending byte
      n = $urandom_range(3, 5);
      for (int i = 0; i < int'(n); i++) begin
        send_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
      end
      if ($urandom_range(0, 1) == 1) begin
        send_byte(8'($urandom_range(0, 127)), 1'b0);
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_random_traffic();
    while (bytes_sent < RandomBytes) begin
      send_random_run();
    end
  endtask

  // Closing phase: both sides stay ready so bytes and results stream at full rate.
  task automatic test_full_rate();
    int unsigned stop_at;
    steady  = 1'b1;
    stop_at = bytes_sent + SteadyBytes;
    while (bytes_sent < stop_at) begin
      send_random_run();
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    mirror_acc      = '0;
    mirror_count    = PosFirst;
    fail_count      = 0;
    bytes_sent      = 0;
    chars_seen      = 0;
    steady          = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_bytes();
    test_two_byte_forms();
    test_three_byte_forms();
    test_error_paths();
    test_random_traffic();
    test_full_rate();

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    // drain: wait for every owed result, then watch for strays
    waited = 0;
    while (pending_chars.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_chars.size());
    end

    $display("Sent %0d bytes, checked %0d decoded words under random idling and at full rate.",
             bytes_sent, chars_seen);
    $display("Status mix: ok %0d, invalid %0d, overlong %0d, too long %0d, truncated %0d.",
             status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_OVERLONG],
             status_seen[ST_TOO_LONG], status_seen[ST_TRUNCATED]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
